// ===== design/gcr_pkg.sv =====
// Package for the gain crossbar router: widths, codes, and the stage types
// shared by the interfaces and the modules. Depends on nothing.
package gcr_pkg;

	localparam int MAX_INLETS  = 8;
	localparam int MAX_OUTLETS = 8;
	localparam int PORT_W      = 3;
	localparam int CNT_W       = 4;
	localparam int GAIN_W      = 32;
	localparam int ADDR_W      = 2 * PORT_W;
	localparam int TABLE_DEPTH = MAX_INLETS * MAX_OUTLETS;
	localparam int REG_IDX_W   = 2;

	localparam logic [CNT_W-1:0]  RESET_COUNT = 4'd2;
	localparam logic [CNT_W-1:0]  INLET_MAX   = 4'(MAX_INLETS);
	localparam logic [CNT_W-1:0]  OUTLET_MAX  = 4'(MAX_OUTLETS);
	localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 32'sd65536;

	typedef enum logic [1:0] {
		OP_ROUTE = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_DUMP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		VK_BANG    = 2'd0,
		VK_INT     = 2'd1,
		VK_FLOAT   = 2'd2,
		VK_UNKNOWN = 2'd3
	} vkind_t;

	typedef enum logic {
		RK_ROUTE = 1'b0,
		RK_DUMP  = 1'b1
	} rkind_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_INLET_COUNT  = 2'd0,
		REG_OUTLET_COUNT = 2'd1,
		REG_DEFAULT_GAIN = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_END
	} state_t;

	typedef struct packed {
		logic                     vld;
		logic                     fin;
		logic                     dump;
		logic [PORT_W-1:0]        inlet;
		logic [PORT_W-1:0]        outlet;
		logic [1:0]               vkind;
		logic signed [GAIN_W-1:0] value;
	} tok_t;

	typedef struct packed {
		logic                     rkind;
		logic [PORT_W-1:0]        port;
		logic signed [GAIN_W-1:0] value;
		logic [1:0]               vkind;
		logic [PORT_W-1:0]        dinlet;
		logic signed [GAIN_W-1:0] dgain;
		logic                     last;
	} result_t;

endpackage

// ===== design/gcr_if.sv =====
// Channel interfaces of the gain crossbar router: operation inlet and result outlet.
// Depends on gcr_pkg for field widths.
interface gcr_in_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        operation;
	logic [7:0]                        inlet_index;
	logic [7:0]                        outlet_index;
	logic signed [gcr_pkg::GAIN_W-1:0] gain;
	logic                              use_default;
	logic signed [gcr_pkg::GAIN_W-1:0] value;
	logic [1:0]                        value_kind;

	modport source (
		output valid, operation, inlet_index, outlet_index, gain, use_default, value,
			value_kind,
		input ready
	);
	modport sink (
		input valid, operation, inlet_index, outlet_index, gain, use_default, value,
			value_kind,
		output ready
	);
endinterface

interface gcr_out_if;
	logic                              valid;
	logic                              ready;
	logic                              result_kind;
	logic [gcr_pkg::PORT_W-1:0]        out_port;
	logic signed [gcr_pkg::GAIN_W-1:0] out_value;
	logic [1:0]                        out_value_kind;
	logic [gcr_pkg::PORT_W-1:0]        dump_inlet;
	logic signed [gcr_pkg::GAIN_W-1:0] dump_gain;
	logic                              last_of_run;

	modport source (
		output valid, result_kind, out_port, out_value, out_value_kind, dump_inlet,
			dump_gain, last_of_run,
		input ready
	);
	modport sink (
		input valid, result_kind, out_port, out_value, out_value_kind, dump_inlet,
			dump_gain, last_of_run,
		output ready
	);
endinterface

// ===== design/gcr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gcr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/gcr_scale.sv =====
// Q16.16 scaling unit: registered 32x32 product, then round to nearest
// (ties up) and saturate to 32 bits. Depends on gcr_pkg.
module gcr_scale (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [gcr_pkg::GAIN_W-1:0] a,
	input  logic signed [gcr_pkg::GAIN_W-1:0] b,
	output logic signed [gcr_pkg::GAIN_W-1:0] result
);

	logic signed [2*gcr_pkg::GAIN_W-1:0] prod_s2;
	logic signed [2*gcr_pkg::GAIN_W-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= a * b;
		end
	end

	always_comb begin
		rnd = prod_s2 + 64'sd32768;
		if (rnd[63:47] == {17{rnd[63]}}) begin
			result = rnd[47:16];
		end else if (rnd[63]) begin
			result = 32'sh8000_0000;
		end else begin
			result = 32'sh7FFF_FFFF;
		end
	end

endmodule

// ===== design/gain_crossbar_router.sv =====
// Gain crossbar router: an 8x8 table of Q16.16 gains in a synchronous RAM with
// valid bits, a sequencer that walks it, the scaling unit and the result stage.
// Depends on gcr_pkg, gcr_if, gcr_ram and gcr_scale.
//
// Set and clear give no result. A route walks every outlet of its inlet and a
// dump every cell of the active inlet_count x outlet_count area: after accepting
// in the idle state, the sequencer reads one table cell per cycle through the
// table's single read port while the outlet does not stall, then closes the run
// in an end state. A result is held until the next connected cell or the end of
// the run is seen; a stalled outlet stalls the whole walk.
// Reset, clear and any change of an effective count empty the table at once.
module gain_crossbar_router (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [gcr_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [gcr_pkg::GAIN_W-1:0]      cfg_data,
	gcr_in_if.sink                          in_ch,
	gcr_out_if.source                       out_ch
);

	localparam int PW = gcr_pkg::PORT_W;

	gcr_pkg::state_t state_q, state_d;

	logic [gcr_pkg::CNT_W-1:0]        in_cnt_q, out_cnt_q, cfg_cnt;
	logic [gcr_pkg::CNT_W-1:0]        in_cnt_m1, out_cnt_m1;
	logic signed [gcr_pkg::GAIN_W-1:0] def_gain_q;
	logic [gcr_pkg::TABLE_DEPTH-1:0]  cell_vld_q;
	logic                             cnt_chg, vld_clr;

	logic [PW-1:0]                    inlet_q, outlet_q;
	logic                             dump_q;
	logic [1:0]                       vkind_q;
	logic signed [gcr_pkg::GAIN_W-1:0] value_q;

	logic                             en, accept, walk_last, tbl_we, start_route;
	logic [gcr_pkg::ADDR_W-1:0]       waddr, raddr;
	logic signed [gcr_pkg::GAIN_W-1:0] wdata, rdata, cell_gain, scaled;

	gcr_pkg::tok_t    issue_tok, tok_s1, tok_s2;
	logic             cvld_s1;
	logic signed [gcr_pkg::GAIN_W-1:0] gain_s2;

	gcr_pkg::result_t new_res, pend_q, out_q, fin_res;
	logic             pend_vld_q, out_vld_q, new_cell, fin_s2, push;

	function automatic logic [gcr_pkg::CNT_W-1:0] clamp_count(
		input logic [gcr_pkg::CNT_W-1:0] v,
		input logic [gcr_pkg::CNT_W-1:0] maxv
	);
		logic [gcr_pkg::CNT_W-1:0] c;
		c = v;
		if (c == '0) begin
			c = 4'd1;
		end
		if (c > maxv) begin
			c = maxv;
		end
		return c;
	endfunction

	// pipeline advances whenever the output register is free or being taken
	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = (state_q == gcr_pkg::ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_cnt_m1   = in_cnt_q - 4'd1;
	assign out_cnt_m1  = out_cnt_q - 4'd1;

	assign start_route = (in_ch.operation == gcr_pkg::OP_ROUTE)
		&& (in_ch.inlet_index < {4'd0, in_cnt_q})
		&& (in_ch.value_kind != gcr_pkg::VK_UNKNOWN);

	assign tbl_we = accept && (in_ch.operation == gcr_pkg::OP_SET)
		&& (in_ch.inlet_index < {4'd0, in_cnt_q})
		&& (in_ch.outlet_index < {4'd0, out_cnt_q});
	assign waddr  = {in_ch.inlet_index[PW-1:0], in_ch.outlet_index[PW-1:0]};
	assign wdata  = in_ch.use_default ? def_gain_q : in_ch.gain;
	assign raddr  = {inlet_q, outlet_q};

	// configuration and valid bits
	always_comb begin
		cfg_cnt = '0;
		case (gcr_pkg::reg_idx_t'(cfg_index))
			gcr_pkg::REG_INLET_COUNT:  cfg_cnt = clamp_count(cfg_data[3:0], gcr_pkg::INLET_MAX);
			gcr_pkg::REG_OUTLET_COUNT: cfg_cnt = clamp_count(cfg_data[3:0], gcr_pkg::OUTLET_MAX);
			default:                   cfg_cnt = '0;
		endcase
	end

	assign cnt_chg = cfg_wr_en
		&& (((gcr_pkg::reg_idx_t'(cfg_index) == gcr_pkg::REG_INLET_COUNT)
				&& (cfg_cnt != in_cnt_q))
			|| ((gcr_pkg::reg_idx_t'(cfg_index) == gcr_pkg::REG_OUTLET_COUNT)
				&& (cfg_cnt != out_cnt_q)));
	assign vld_clr = cnt_chg || (accept && in_ch.operation == gcr_pkg::OP_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q   <= gcr_pkg::RESET_COUNT;
			out_cnt_q  <= gcr_pkg::RESET_COUNT;
			def_gain_q <= gcr_pkg::UNITY_GAIN;
			cell_vld_q <= '0;
		end else begin
			if (vld_clr) begin
				cell_vld_q <= '0;
			end else if (tbl_we) begin
				cell_vld_q[waddr] <= 1'b1;
			end
			if (cfg_wr_en) begin
				case (gcr_pkg::reg_idx_t'(cfg_index))
					gcr_pkg::REG_INLET_COUNT: begin
						if (cfg_cnt != in_cnt_q) begin
							in_cnt_q <= cfg_cnt;
						end
					end
					gcr_pkg::REG_OUTLET_COUNT: begin
						if (cfg_cnt != out_cnt_q) begin
							out_cnt_q <= cfg_cnt;
						end
					end
					gcr_pkg::REG_DEFAULT_GAIN: begin
						def_gain_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		issue_tok = '0;
		walk_last = dump_q ? (inlet_q == in_cnt_m1[PW-1:0] && outlet_q == out_cnt_m1[PW-1:0])
			: (outlet_q == '0);
		issue_tok.dump   = dump_q;
		issue_tok.inlet  = inlet_q;
		issue_tok.outlet = outlet_q;
		issue_tok.vkind  = vkind_q;
		issue_tok.value  = value_q;
		case (state_q)
			gcr_pkg::ST_IDLE: begin
				if (accept && (start_route || in_ch.operation == gcr_pkg::OP_DUMP)) begin
					state_d = gcr_pkg::ST_WALK;
				end
			end
			gcr_pkg::ST_WALK: begin
				issue_tok.vld = 1'b1;
				if (en && walk_last) begin
					state_d = gcr_pkg::ST_END;
				end
			end
			gcr_pkg::ST_END: begin
				issue_tok.vld = 1'b1;
				issue_tok.fin = 1'b1;
				if (en) begin
					state_d = gcr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_ch.operation == gcr_pkg::OP_DUMP) begin
				dump_q   <= 1'b1;
				inlet_q  <= '0;
				outlet_q <= '0;
			end else begin
				dump_q   <= 1'b0;
				inlet_q  <= in_ch.inlet_index[PW-1:0];
				outlet_q <= out_cnt_m1[PW-1:0];
			end
			vkind_q <= in_ch.value_kind;
			value_q <= (in_ch.value_kind == gcr_pkg::VK_INT)
				? {in_ch.value[31:16], 16'd0} : in_ch.value;
		end else if (state_q == gcr_pkg::ST_WALK && en && !walk_last) begin
			if (!dump_q) begin
				outlet_q <= outlet_q - 3'd1;
			end else if (outlet_q == out_cnt_m1[PW-1:0]) begin
				outlet_q <= '0;
				inlet_q  <= inlet_q + 3'd1;
			end else begin
				outlet_q <= outlet_q + 3'd1;
			end
		end
	end

	gcr_ram #(
		.WIDTH(gcr_pkg::GAIN_W),
		.DEPTH(gcr_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// stage 1: cell read; stage 2: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else if (en) begin
			tok_s1 <= issue_tok;
			tok_s2 <= tok_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cvld_s1 <= cell_vld_q[raddr];
			gain_s2 <= cell_gain;
		end
	end

	assign cell_gain = cvld_s1 ? rdata : '0;

	gcr_scale u_scale (
		.clk    (clk),
		.en     (en),
		.a      (tok_s1.value),
		.b      (cell_gain),
		.result (scaled)
	);

	// stage 3: hold the latest result back until the next one or the run end
	always_comb begin
		new_res        = '0;
		new_res.port   = tok_s2.outlet;
		if (tok_s2.dump) begin
			new_res.rkind  = gcr_pkg::RK_DUMP;
			new_res.dinlet = tok_s2.inlet;
			new_res.dgain  = gain_s2;
		end else begin
			new_res.rkind = gcr_pkg::RK_ROUTE;
			case (tok_s2.vkind)
				gcr_pkg::VK_BANG: begin
					new_res.vkind = gcr_pkg::VK_BANG;
				end
				gcr_pkg::VK_INT: begin
					if (gain_s2 == gcr_pkg::UNITY_GAIN) begin
						new_res.vkind = gcr_pkg::VK_INT;
						new_res.value = tok_s2.value;
					end else begin
						new_res.vkind = gcr_pkg::VK_FLOAT;
						new_res.value = scaled;
					end
				end
				default: begin
					new_res.vkind = gcr_pkg::VK_FLOAT;
					new_res.value = scaled;
				end
			endcase
		end
	end

	assign new_cell = tok_s2.vld && !tok_s2.fin && (gain_s2 != '0);
	assign fin_s2   = tok_s2.vld && tok_s2.fin;
	assign push     = en && pend_vld_q && (new_cell || fin_s2);

	always_comb begin
		fin_res      = pend_q;
		fin_res.last = fin_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (en) begin
				if (new_cell) begin
					pend_vld_q <= 1'b1;
				end else if (fin_s2) begin
					pend_vld_q <= 1'b0;
				end
				out_vld_q <= push;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && new_cell) begin
			pend_q <= new_res;
		end
		if (push) begin
			out_q <= fin_res;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.result_kind    = out_q.rkind;
	assign out_ch.out_port       = out_q.port;
	assign out_ch.out_value      = out_q.value;
	assign out_ch.out_value_kind = out_q.vkind;
	assign out_ch.dump_inlet     = out_q.dinlet;
	assign out_ch.dump_gain      = out_q.dgain;
	assign out_ch.last_of_run    = out_q.last;

endmodule

// ===== tb/gain_crossbar_router_test.sv =====
`timescale 1ns / 100ps
// Self-checking test of gain_crossbar_router: directed and random operation transactions
// checked against an in-bench model of the gain table, with random stalls on both channels.
// Depends on gcr_pkg, gcr_in_if, gcr_out_if and the gain_crossbar_router RTL.
module gain_crossbar_router_test;
	import gcr_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int GAP_MAX      = 12;
	localparam int DRAIN_CYCLES = 80;
	localparam int IDLE_LIMIT   = 2000;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [31:0]   Q_MAX      = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]   Q_MIN      = 32'sh8000_0000;

	typedef struct {
		op_t                op;
		logic [7:0]         inlet;
		logic [7:0]         outlet;
		logic signed [31:0] gain;
		logic               use_def;
		logic signed [31:0] value;
		logic [1:0]         vkind;
	} router_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_data;

	gcr_in_if  in_ch ();
	gcr_out_if out_ch ();

	gain_crossbar_router u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	logic signed [31:0] gain_cells [MAX_INLETS][MAX_OUTLETS];
	int unsigned        inlet_cnt;
	int unsigned        outlet_cnt;
	logic signed [31:0] dflt_gain;
	result_t            pending_results [$];
	int                 fail_count;
	int unsigned        gap_max_in;
	int unsigned        gap_max_out;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void clear_cells();
		foreach (gain_cells[a, b])
			gain_cells[a][b] = '0;
	endfunction

	function automatic void add_result(result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic int unsigned clamp_cnt(logic [31:0] d, int unsigned maxv);
		int unsigned c;
		c = d[3:0];
		if (c < 1)
			c = 1;
		if (c > maxv)
			c = maxv;
		return c;
	endfunction

	function automatic void apply_reg_write(logic [REG_IDX_W-1:0] idx, logic [31:0] d);
		int unsigned c;
		case (idx)
			REG_INLET_COUNT: begin
				c = clamp_cnt(d, MAX_INLETS);
				if (c != inlet_cnt) begin
					inlet_cnt = c;
					clear_cells();
				end
			end
			REG_OUTLET_COUNT: begin
				c = clamp_cnt(d, MAX_OUTLETS);
				if (c != outlet_cnt) begin
					outlet_cnt = c;
					clear_cells();
				end
			end
			REG_DEFAULT_GAIN: dflt_gain = d;
			default: ;
		endcase
	endfunction

	function automatic logic signed [31:0] scale_q16(logic signed [31:0] a, logic signed [31:0] g);
		longint p;
		p = longint'(a) * longint'(g) + 64'sd32768;
		p = p >>> 16;
		if (p > longint'(Q_MAX))
			return Q_MAX;
		if (p < longint'(Q_MIN))
			return Q_MIN;
		return p[31:0];
	endfunction

	function automatic void predict_router_results(router_cmd_t c);
		result_t            r;
		logic signed [31:0] cgain;
		logic signed [31:0] ipart;
		int                 n;
		int                 a;
		int                 b;
		n = pending_results.size();
		case (c.op)
			OP_SET: begin
				if (c.inlet < inlet_cnt && c.outlet < outlet_cnt)
					gain_cells[c.inlet][c.outlet] = c.use_def ? dflt_gain : c.gain;
			end
			OP_CLEAR: clear_cells();
			OP_DUMP: begin
				for (a = 0; a < inlet_cnt; a++) begin
					for (b = 0; b < outlet_cnt; b++) begin
						if (gain_cells[a][b] != 0) begin
							r = '0;
							r.rkind = RK_DUMP;
							r.port = b[PORT_W-1:0];
							r.dinlet = a[PORT_W-1:0];
							r.dgain = gain_cells[a][b];
							add_result(r);
						end
					end
				end
			end
			default: begin
				if (c.inlet < inlet_cnt && c.vkind != VK_UNKNOWN) begin
					ipart = c.value & 32'shFFFF_0000;
					for (b = outlet_cnt - 1; b >= 0; b--) begin
						cgain = gain_cells[c.inlet][b];
						if (cgain != 0) begin
							r = '0;
							r.rkind = RK_ROUTE;
							r.port = b[PORT_W-1:0];
							if (c.vkind == VK_BANG) begin
								r.vkind = VK_BANG;
							end else if (c.vkind == VK_INT && cgain == UNITY_GAIN) begin
								r.vkind = VK_INT;
								r.value = ipart;
							end else if (c.vkind == VK_INT) begin
								r.vkind = VK_FLOAT;
								r.value = scale_q16(ipart, cgain);
							end else begin
								r.vkind = VK_FLOAT;
								r.value = scale_q16(c.value, cgain);
							end
							add_result(r);
						end
					end
				end
			end
		endcase
		if (pending_results.size() > n)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	function automatic router_cmd_t make_cmd(op_t op, logic [7:0] inlet, logic [7:0] outlet,
			logic signed [31:0] gain, logic use_def, logic signed [31:0] value, logic [1:0] vkind);
		router_cmd_t c;
		c.op = op;
		c.inlet = inlet;
		c.outlet = outlet;
		c.gain = gain;
		c.use_def = use_def;
		c.value = value;
		c.vkind = vkind;
		return c;
	endfunction

	function automatic logic signed [31:0] random_q16();
		logic signed [31:0] s;
		case ($urandom_range(7))
			0: return UNITY_GAIN;
			1: return Q_MAX;
			2: return Q_MIN;
			3: return 32'sd0;
			4, 5: begin
				s = $urandom_range(32'h0004_0000);
				if ($urandom_range(1))
					s = -s;
				return s;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic router_cmd_t random_cmd();
		router_cmd_t c;
		int unsigned pick;
		pick = $urandom_range(99);
		c.op = OP_ROUTE;
		c.inlet = $urandom_range(inlet_cnt - 1);
		c.outlet = $urandom_range(outlet_cnt - 1);
		c.gain = random_q16();
		c.use_def = ($urandom_range(9) == 0);
		c.value = random_q16();
		c.vkind = $urandom_range(2);
		if (pick < 45) begin
			c.op = OP_SET;
		end else if (pick < 85) begin
			c.op = OP_ROUTE;
		end else if (pick < 90) begin
			c.op = OP_DUMP;
		end else if (pick < 92) begin
			c.op = OP_CLEAR;
		end else begin
			c.op = op_t'($urandom_range(3));
			c.inlet = $urandom_range(255);
			c.outlet = $urandom_range(255);
			c.use_def = $urandom_range(1);
			c.vkind = $urandom_range(3);
		end
		return c;
	endfunction

	task automatic send_cmd(input router_cmd_t c);
		int unsigned gap;
		gap = $urandom_range(gap_max_in);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= c.op;
		in_ch.inlet_index <= c.inlet;
		in_ch.outlet_index <= c.outlet;
		in_ch.gain <= c.gain;
		in_ch.use_default <= c.use_def;
		in_ch.value <= c.value;
		in_ch.value_kind <= c.vkind;
		do @(posedge clk); while (!in_ch.ready);
		predict_router_results(c);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		apply_reg_write(idx, d);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic quiesce();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic test_reset_state();
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd1, 32'sd0, 1'b1, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd1, 8'd0, -32'sd32768, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd2, 8'd0, UNITY_GAIN, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd2, UNITY_GAIN, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sh0003_8000, VK_INT));
		send_cmd(make_cmd(OP_ROUTE, 8'd1, 8'd0, 32'sd0, 1'b0, 32'sh0003_8001, VK_FLOAT));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_UNKNOWN));
		send_cmd(make_cmd(OP_ROUTE, 8'd2, 8'd0, 32'sd0, 1'b0, 32'sh0001_0000, VK_INT));
	endtask

	task automatic test_extremes();
		quiesce();
		write_reg(REG_INLET_COUNT, 32'd8);
		write_reg(REG_OUTLET_COUNT, 32'd8);
		write_reg(REG_DEFAULT_GAIN, Q_MIN);
		send_cmd(make_cmd(OP_SET, 8'd7, 8'd7, 32'sd0, 1'b1, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd0, Q_MAX, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd7, UNITY_GAIN, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd3, 32'sd1, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd255, 8'd255, Q_MAX, 1'b1, Q_MAX, VK_UNKNOWN));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, Q_MAX, VK_FLOAT));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, Q_MIN, VK_FLOAT));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, Q_MIN, VK_INT));
		send_cmd(make_cmd(OP_ROUTE, 8'd7, 8'd0, 32'sd0, 1'b0, Q_MIN, VK_FLOAT));
		send_cmd(make_cmd(OP_ROUTE, 8'd7, 8'd255, Q_MAX, 1'b1, Q_MAX, VK_BANG));
		send_cmd(make_cmd(OP_ROUTE, 8'd255, 8'd0, 32'sd0, 1'b0, Q_MAX, VK_FLOAT));
		send_cmd(make_cmd(OP_DUMP, 8'd255, 8'd255, Q_MAX, 1'b1, Q_MAX, VK_UNKNOWN));
		send_cmd(make_cmd(OP_CLEAR, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, Q_MAX, VK_FLOAT));
	endtask

	task automatic test_count_rules();
		quiesce();
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd0, 32'sh0002_0000, 1'b0, 32'sd0, VK_BANG));
		quiesce();
		write_reg(REG_OUTLET_COUNT, 32'd8);
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		quiesce();
		write_reg(REG_INLET_COUNT, 32'hFFFF_FFF0);
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_SET, 8'd0, 8'd0, 32'sd0, 1'b1, 32'sd0, VK_BANG));
		quiesce();
		write_reg(REG_INLET_COUNT, 32'd1);
		write_reg(REG_OUTLET_COUNT, 32'd9);
		write_reg(REG_UNUSED, 32'd0);
		write_reg(REG_OUTLET_COUNT, 32'hA5A5_A5AF);
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		quiesce();
		write_reg(REG_OUTLET_COUNT, 32'd0);
		send_cmd(make_cmd(OP_DUMP, 8'd0, 8'd0, 32'sd0, 1'b0, 32'sd0, VK_BANG));
		send_cmd(make_cmd(OP_ROUTE, 8'd0, 8'd0, 32'sd0, 1'b0, UNITY_GAIN, VK_INT));
	endtask

	task automatic run_random_phase(input logic [31:0] inlets, input logic [31:0] outlets,
			input logic [31:0] dgain, input bit gaps_on, input int n_items, input bit hold_mid);
		int i;
		quiesce();
		write_reg(REG_INLET_COUNT, inlets);
		write_reg(REG_OUTLET_COUNT, outlets);
		write_reg(REG_DEFAULT_GAIN, dgain);
		gap_max_in = gaps_on ? GAP_MAX : 0;
		gap_max_out = gaps_on ? GAP_MAX : 0;
		for (i = 0; i < n_items; i++) begin
			send_cmd(random_cmd());
			if (hold_mid && i == n_items / 2)
				hold_until_drained();
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(32'd1, 32'd1, Q_MAX, 1'b1, 60, 1'b0);
		run_random_phase(32'd8, 32'd8, $urandom, 1'b1, 65, 1'b1);
		run_random_phase(32'd8, 32'd8, random_q16(), 1'b0, 60, 1'b0);
		run_random_phase($urandom, $urandom, $urandom, 1'b1, 65, 1'b0);
		run_random_phase(32'd8, 32'd1, UNITY_GAIN, 1'b1, 60, 1'b1);
		run_random_phase(32'd1, 32'd8, Q_MIN, 1'b1, 60, 1'b0);
	endtask

	initial begin : result_checker
		result_t     want;
		int unsigned stall;
		out_ch.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			stall = $urandom_range(gap_max_out);
			if (stall != 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$error("unexpected result on outlet %0d", out_ch.out_port);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", want.rkind, out_ch.result_kind);
				check_field("out_port", want.port, out_ch.out_port);
				check_field("out_value", want.value, out_ch.out_value);
				check_field("out_value_kind", want.vkind, out_ch.out_value_kind);
				check_field("dump_inlet", want.dinlet, out_ch.dump_inlet);
				check_field("dump_gain", want.dgain, out_ch.dump_gain);
				check_field("last_of_run", want.last, out_ch.last_of_run);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle = 0;
			else
				idle++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : sequencer
		fail_count = 0;
		gap_max_in = GAP_MAX;
		gap_max_out = GAP_MAX;
		inlet_cnt = RESET_COUNT;
		outlet_cnt = RESET_COUNT;
		dflt_gain = UNITY_GAIN;
		clear_cells();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_INLET_COUNT;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_ROUTE;
		in_ch.inlet_index <= '0;
		in_ch.outlet_index <= '0;
		in_ch.gain <= '0;
		in_ch.use_default <= 1'b0;
		in_ch.value <= '0;
		in_ch.value_kind <= VK_BANG;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_extremes();
		test_count_rules();
		test_random_traffic();

		quiesce();
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
